// File: hdl/gmbd_pkg.sv
// ----------------------------------------------------------------------------
// gmbd_pkg
// Shared types, layout tables and lookup function of the codeword block
// deinterleaver.
// ----------------------------------------------------------------------------
package gmbd_pkg;

    localparam int NUM_VERSIONS = 13;
    localparam int NUM_LEVELS   = 5;
    localparam int TAB_DEPTH    = NUM_VERSIONS * NUM_LEVELS;

    localparam logic [3:0] VERSION_RESET = 4'd1;
    localparam logic [2:0] LEVEL_RESET   = 3'd1;

    // configuration register indexes
    typedef logic [0:0] cfg_addr_t;
    localparam cfg_addr_t CFG_VERSION  = 1'b0;
    localparam cfg_addr_t CFG_EC_LEVEL = 1'b1;

    typedef struct packed {
        logic [6:0] n1;
        logic [3:0] b1;
        logic [3:0] nb;
        logic [5:0] e1;
        logic [3:0] b3;
        logic [5:0] e2;
    } layout_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] block_index;
        logic [6:0] position;
        logic       is_data;
        logic [6:0] data_length;
        logic       last;
    } result_t;

    localparam logic [6:0] N1_TAB [NUM_VERSIONS] = '{
        7'd18, 7'd50, 7'd98, 7'd81, 7'd121, 7'd113, 7'd113,
        7'd116, 7'd121, 7'd126, 7'd118, 7'd125, 7'd122
    };
    localparam logic [3:0] B1_TAB [NUM_VERSIONS] = '{
        4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd7, 4'd5, 4'd10, 4'd6
    };
    localparam logic [3:0] B2_TAB [NUM_VERSIONS] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd4, 4'd0, 4'd4, 4'd0, 4'd6
    };

    // per version, five levels each
    localparam logic [5:0] E1_TAB [TAB_DEPTH] = '{
        6'd0,  6'd3,  6'd5,  6'd7,  6'd9,
        6'd5,  6'd10, 6'd15, 6'd20, 6'd25,
        6'd9,  6'd19, 6'd29, 6'd39, 6'd49,
        6'd8,  6'd16, 6'd24, 6'd32, 6'd41,
        6'd12, 6'd24, 6'd36, 6'd48, 6'd61,
        6'd11, 6'd23, 6'd34, 6'd45, 6'd57,
        6'd12, 6'd23, 6'd34, 6'd45, 6'd57,
        6'd12, 6'd23, 6'd35, 6'd47, 6'd58,
        6'd12, 6'd24, 6'd36, 6'd48, 6'd61,
        6'd13, 6'd26, 6'd38, 6'd51, 6'd63,
        6'd12, 6'd24, 6'd36, 6'd47, 6'd59,
        6'd13, 6'd25, 6'd38, 6'd50, 6'd63,
        6'd13, 6'd25, 6'd37, 6'd49, 6'd61
    };
    localparam logic [3:0] B3_TAB [TAB_DEPTH] = '{
        4'd0, 4'd1,  4'd1, 4'd1,  4'd1,
        4'd1, 4'd1,  4'd1, 4'd1,  4'd1,
        4'd1, 4'd1,  4'd1, 4'd1,  4'd1,
        4'd2, 4'd2,  4'd2, 4'd2,  4'd1,
        4'd2, 4'd2,  4'd2, 4'd2,  4'd1,
        4'd3, 4'd1,  4'd2, 4'd3,  4'd1,
        4'd1, 4'd2,  4'd3, 4'd4,  4'd1,
        4'd2, 4'd5,  4'd3, 4'd1,  4'd4,
        4'd6, 4'd6,  4'd6, 4'd6,  4'd1,
        4'd4, 4'd1,  4'd5, 4'd2,  4'd7,
        4'd6, 4'd4,  4'd2, 4'd9,  4'd7,
        4'd5, 4'd10, 4'd5, 4'd10, 4'd5,
        4'd1, 4'd3,  4'd5, 4'd7,  4'd9
    };
    localparam logic [5:0] E2_TAB [TAB_DEPTH] = '{
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd40,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd60,
        6'd0,  6'd22, 6'd33, 6'd0,  6'd56,
        6'd11, 6'd22, 6'd33, 6'd0,  6'd56,
        6'd11, 6'd0,  6'd34, 6'd46, 6'd57,
        6'd0,  6'd0,  6'd0,  6'd0,  6'd60,
        6'd12, 6'd25, 6'd37, 6'd50, 6'd0,
        6'd11, 6'd23, 6'd35, 6'd0,  6'd58,
        6'd12, 6'd0,  6'd37, 6'd0,  6'd62,
        6'd12, 6'd24, 6'd36, 6'd48, 6'd60
    };

    function automatic layout_t layout_lookup(input logic [3:0] version,
                                              input logic [2:0] ec_level);
        logic [3:0] vi;
        logic [2:0] li;
        logic [6:0] idx;
        layout_t    lay;
        if (version == 4'd0) begin
            vi = 4'd0;
        end else if (version > 4'(NUM_VERSIONS)) begin
            vi = 4'(NUM_VERSIONS - 1);
        end else begin
            vi = version - 4'd1;
        end
        if (ec_level == 3'd0) begin
            li = 3'd0;
        end else if (ec_level > 3'(NUM_LEVELS)) begin
            li = 3'(NUM_LEVELS - 1);
        end else begin
            li = ec_level - 3'd1;
        end
        idx    = 7'({3'd0, vi} * 7'd5) + {4'd0, li};
        lay.n1 = N1_TAB[vi];
        lay.b1 = B1_TAB[vi];
        lay.nb = B1_TAB[vi] + B2_TAB[vi];
        lay.e1 = E1_TAB[idx];
        lay.b3 = B3_TAB[idx];
        lay.e2 = E2_TAB[idx];
        return lay;
    endfunction

endpackage

// File: hdl/gmbd_layout.sv
// ----------------------------------------------------------------------------
// gmbd_layout
// Configuration registers and the registered block layout looked up from
// the version and error-correction level tables.
// ----------------------------------------------------------------------------
module gmbd_layout (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  gmbd_pkg::cfg_addr_t  cfg_addr,
    input  logic [3:0]           cfg_wr_data,
    output gmbd_pkg::layout_t    layout
);

    logic [3:0]        version_reg, version_next;
    logic [2:0]        level_reg, level_next;
    gmbd_pkg::layout_t layout_reg, layout_next;

    always_comb begin
        version_next = version_reg;
        level_next   = level_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                gmbd_pkg::CFG_VERSION:  version_next = cfg_wr_data;
                gmbd_pkg::CFG_EC_LEVEL: level_next   = cfg_wr_data[2:0];
                default: ;
            endcase
        end
        layout_next = gmbd_pkg::layout_lookup(version_next, level_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= gmbd_pkg::VERSION_RESET;
            level_reg   <= gmbd_pkg::LEVEL_RESET;
            layout_reg  <= gmbd_pkg::layout_lookup(gmbd_pkg::VERSION_RESET,
                                                   gmbd_pkg::LEVEL_RESET);
        end else begin
            version_reg <= version_next;
            level_reg   <= level_next;
            layout_reg  <= layout_next;
        end
    end

    assign layout = layout_reg;

endmodule

// File: hdl/gmbd_tagger.sv
// ----------------------------------------------------------------------------
// gmbd_tagger
// Block and position counters; tags each accepted codeword with its block,
// position, data length and last flag.
// ----------------------------------------------------------------------------
module gmbd_tagger (
    input  logic               aclk,
    input  logic               aresetn,
    input  gmbd_pkg::layout_t  layout,
    input  logic               in_accept,
    input  logic [7:0]         codeword,
    input  logic               start_req,
    output logic               res_valid,
    output gmbd_pkg::result_t  res
);

    logic [3:0] blk_reg, blk_next;
    logic [6:0] col_reg, col_next;
    logic       done_reg, done_next;

    logic [3:0] blk;
    logic [6:0] pos;
    logic       done;
    logic [6:0] n2;
    logic [4:0] blk_inc;
    logic       out_of_range;
    logic [6:0] bsize;
    logic [6:0] elen;
    logic [6:0] dlen;
    logic       fin;

    always_comb begin
        blk  = start_req ? 4'd0 : blk_reg;
        pos  = start_req ? 7'd0 : col_reg;
        done = start_req ? 1'b0 : done_reg;

        n2           = layout.n1 - 7'd1;
        blk_inc      = {1'b0, blk} + 5'd1;
        out_of_range = (blk >= layout.nb) || (pos > n2) ||
                       ((pos == n2) && (blk >= layout.b1));
        bsize        = (blk < layout.b1) ? layout.n1 : n2;
        elen         = (blk < layout.b3) ? {1'b0, layout.e1} : {1'b0, layout.e2};
        dlen         = bsize - elen;
        fin          = (pos == n2) && (blk_inc == {1'b0, layout.b1});

        res.byte_out    = codeword;
        res.block_index = blk;
        res.position    = pos;
        res.is_data     = pos < dlen;
        res.data_length = dlen;
        res.last        = fin;
        res_valid       = in_accept && !done && !out_of_range;

        blk_next  = blk_reg;
        col_next  = col_reg;
        done_next = done_reg;
        if (in_accept) begin
            priority if (done) begin
                blk_next  = blk;
                col_next  = pos;
                done_next = done;
            end else if (out_of_range || fin) begin
                blk_next  = 4'd0;
                col_next  = 7'd0;
                done_next = 1'b1;
            end else if ((pos < n2) && (blk_inc >= {1'b0, layout.nb})) begin
                blk_next  = 4'd0;
                col_next  = pos + 7'd1;
                done_next = 1'b0;
            end else begin
                blk_next  = blk_inc[3:0];
                col_next  = pos;
                done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg  <= 4'd0;
            col_reg  <= 7'd0;
            done_reg <= 1'b0;
        end else begin
            blk_reg  <= blk_next;
            col_reg  <= col_next;
            done_reg <= done_next;
        end
    end

endmodule

// File: hdl/gmbd_out_slice.sv
// ----------------------------------------------------------------------------
// gmbd_out_slice
// Result register with a skid stage, so the input side keeps running for
// one transaction while the receiver stalls.
// ----------------------------------------------------------------------------
module gmbd_out_slice (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  gmbd_pkg::result_t  res,
    output logic               in_ready,
    output logic               out_valid,
    output gmbd_pkg::result_t  out_res,
    input  logic               out_ready
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    gmbd_pkg::result_t main_reg, main_next;
    gmbd_pkg::result_t skid_reg, skid_next;
    logic              pop;

    always_comb begin
        pop             = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!main_valid_reg || pop) begin
                main_next       = res;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

// File: hdl/grid_matrix_block_deinterleaver_core.sv
// ----------------------------------------------------------------------------
// grid_matrix_block_deinterleaver_core
// Tags raw codewords of a grid matrix symbol with block and position.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one raw codeword per transaction, s_tuser marks the
//   first codeword of a symbol and restarts the counters
//   m_ channel gives one tagged codeword per result, m_tlast on the final
//   codeword of the symbol, m_tuser set for data and clear for ecc
//   bytes outside the layout or after the final codeword give no result
//   until the next start
//   version and ec_level are written through cfg_wr_en / cfg_addr /
//   cfg_wr_data while no transaction is in flight
//   the result is registered: the tag is worked out combinationally and
//   captured in the result register, or in the skid stage on a stall
//   throughput: one codeword per cycle while the receiver takes results
//   reset: counters cleared, version 1, ec_level 1, no result pending
//   receiver stall: the skid stage absorbs one more transaction, then
//   s_tready drops until the result register drains
// ----------------------------------------------------------------------------
module grid_matrix_block_deinterleaver_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  gmbd_pkg::cfg_addr_t cfg_addr,
    input  logic [3:0]          cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // codeword
    input  logic                s_tuser,   // start_req
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // byte_out, block_index, position, data_length
    output logic                m_tuser,   // is_data
    output logic                m_tlast
);

    gmbd_pkg::layout_t layout;
    gmbd_pkg::result_t res;
    gmbd_pkg::result_t out_res;
    logic              res_valid;
    logic              in_accept;

    assign in_accept = s_tvalid && s_tready;

    gmbd_layout u_layout (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .layout      (layout)
    );

    gmbd_tagger u_tagger (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .layout    (layout),
        .in_accept (in_accept),
        .codeword  (s_tdata),
        .start_req (s_tuser),
        .res_valid (res_valid),
        .res       (res)
    );

    gmbd_out_slice u_out_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'd0, out_res.data_length, out_res.position,
                      out_res.block_index, out_res.byte_out};
    assign m_tuser = out_res.is_data;
    assign m_tlast = out_res.last;

endmodule

// File: hdl/gmbd_checker.sv
// ----------------------------------------------------------------------------
// gmbd_checker
// Port-level checks of the codeword block deinterleaver, bound to the top.
// ----------------------------------------------------------------------------
module gmbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // nothing pending right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    // data flag agrees with position and data length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[18:12] < m_tdata[25:19])))
        else $error("data flag inconsistent with position");

    // block index within range, padding bits clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:8] <= 4'd11) && (m_tdata[31:26] == 6'd0))
        else $error("result fields out of range");

    // the input side is ready whenever no result is pending on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind grid_matrix_block_deinterleaver_core gmbd_checker u_gmbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/gmbd_tag_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gmbd_tag_checker
// Watches the codeword and tag channels of the block deinterleaver. It keeps
// its own copy of the layout tables, the configuration and the block and
// column counters. From these it works out the tag of every accepted
// codeword and compares the tags that come out with them in order.
// ----------------------------------------------------------------------------
module gmbd_tag_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  gmbd_pkg::cfg_addr_t cfg_addr,
    input  logic [3:0]          cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,   // codeword
    input  logic                s_tuser,   // start_req
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [31:0]         m_tdata,   // byte_out, block_index, position, data_length
    input  logic                m_tuser,   // is_data
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int LAYOUT_ROWS = 13;

    localparam int LONG_SIZE [LAYOUT_ROWS] = '{
        18, 50, 98, 81, 121, 113, 113, 116, 121, 126, 118, 125, 122
    };
    localparam int LONG_BLOCKS [LAYOUT_ROWS] = '{
        1, 1, 1, 2, 2, 2, 2, 3, 2, 7, 5, 10, 6
    };
    localparam int SHORT_BLOCKS [LAYOUT_ROWS] = '{
        0, 0, 0, 0, 0, 1, 2, 2, 4, 0, 4, 0, 6
    };
    // e1, split block, e2 for each level
    localparam int ECC_SPLIT [LAYOUT_ROWS][5][3] = '{
        '{'{ 0, 0,  0}, '{ 3,  1,  0}, '{ 5, 1,  0}, '{ 7,  1,  0}, '{ 9, 1,  0}},
        '{'{ 5, 1,  0}, '{10,  1,  0}, '{15, 1,  0}, '{20,  1,  0}, '{25, 1,  0}},
        '{'{ 9, 1,  0}, '{19,  1,  0}, '{29, 1,  0}, '{39,  1,  0}, '{49, 1,  0}},
        '{'{ 8, 2,  0}, '{16,  2,  0}, '{24, 2,  0}, '{32,  2,  0}, '{41, 1, 40}},
        '{'{12, 2,  0}, '{24,  2,  0}, '{36, 2,  0}, '{48,  2,  0}, '{61, 1, 60}},
        '{'{11, 3,  0}, '{23,  1, 22}, '{34, 2, 33}, '{45,  3,  0}, '{57, 1, 56}},
        '{'{12, 1, 11}, '{23,  2, 22}, '{34, 3, 33}, '{45,  4,  0}, '{57, 1, 56}},
        '{'{12, 2, 11}, '{23,  5,  0}, '{35, 3, 34}, '{47,  1, 46}, '{58, 4, 57}},
        '{'{12, 6,  0}, '{24,  6,  0}, '{36, 6,  0}, '{48,  6,  0}, '{61, 1, 60}},
        '{'{13, 4, 12}, '{26,  1, 25}, '{38, 5, 37}, '{51,  2, 50}, '{63, 7,  0}},
        '{'{12, 6, 11}, '{24,  4, 23}, '{36, 2, 35}, '{47,  9,  0}, '{59, 7, 58}},
        '{'{13, 5, 12}, '{25, 10,  0}, '{38, 5, 37}, '{50, 10,  0}, '{63, 5, 62}},
        '{'{13, 1, 12}, '{25,  3, 24}, '{37, 5, 36}, '{49,  7, 48}, '{61, 9, 60}}
    };

    logic [3:0]        version_q;
    logic [2:0]        level_q;
    int                cur_block;
    int                cur_column;
    bit                symbol_done;
    int                errors;
    gmbd_pkg::result_t expected_tags [$];

    function automatic bit tag_codeword(input logic [7:0] cw, input logic start,
                                        output gmbd_pkg::result_t tag);
        int vi;
        int li;
        int n1;
        int n2;
        int b1;
        int nb;
        int e1;
        int b3;
        int e2;
        int dlen;
        tag = '0;
        vi  = (version_q == 4'd0) ? 0 : (version_q > 4'd13) ? 12 : int'(version_q) - 1;
        li  = (level_q == 3'd0) ? 0 : (level_q > 3'd5) ? 4 : int'(level_q) - 1;
        if (start) begin
            cur_block   = 0;
            cur_column  = 0;
            symbol_done = 1'b0;
        end
        if (symbol_done) begin
            return 1'b0;
        end
        n1 = LONG_SIZE[vi];
        n2 = n1 - 1;
        b1 = LONG_BLOCKS[vi];
        nb = b1 + SHORT_BLOCKS[vi];
        e1 = ECC_SPLIT[vi][li][0];
        b3 = ECC_SPLIT[vi][li][1];
        e2 = ECC_SPLIT[vi][li][2];
        // counters left outside the layout by a configuration change
        if (cur_block >= nb || cur_column > n2 || (cur_column == n2 && cur_block >= b1)) begin
            cur_block   = 0;
            cur_column  = 0;
            symbol_done = 1'b1;
            return 1'b0;
        end
        dlen            = ((cur_block < b1) ? n1 : n2) - ((cur_block < b3) ? e1 : e2);
        tag.byte_out    = cw;
        tag.block_index = 4'(cur_block);
        tag.position    = 7'(cur_column);
        tag.is_data     = (cur_column < dlen);
        tag.data_length = 7'(dlen);
        tag.last        = (cur_column == n2) && (cur_block + 1 == b1);
        if (tag.last) begin
            cur_block   = 0;
            cur_column  = 0;
            symbol_done = 1'b1;
        end else if (cur_column < n2 && cur_block + 1 >= nb) begin
            cur_block  = 0;
            cur_column = cur_column + 1;
        end else begin
            cur_block = cur_block + 1;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        gmbd_pkg::result_t tag;
        gmbd_pkg::result_t seen;
        if (!aresetn) begin
            version_q   = 4'd1;
            level_q     = 3'd1;
            cur_block   = 0;
            cur_column  = 0;
            symbol_done = 1'b0;
            errors      = 0;
            expected_tags.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == gmbd_pkg::CFG_VERSION) begin
                    version_q = cfg_wr_data;
                end else if (cfg_addr == gmbd_pkg::CFG_EC_LEVEL) begin
                    level_q = cfg_wr_data[2:0];
                end
            end
            if (s_tvalid && s_tready) begin
                if (tag_codeword(s_tdata, s_tuser, tag)) begin
                    expected_tags.push_back(tag);
                end
            end
            if (m_tvalid && m_tready) begin
                seen.byte_out    = m_tdata[7:0];
                seen.block_index = m_tdata[11:8];
                seen.position    = m_tdata[18:12];
                seen.data_length = m_tdata[25:19];
                seen.is_data     = m_tuser;
                seen.last        = m_tlast;
                if (expected_tags.size() == 0) begin
                    $display("%0t: unexpected tag transaction %h", $time, seen);
                    errors++;
                end else begin
                    tag = expected_tags.pop_front();
                    if (seen !== tag) begin
                        $display("%0t: tag mismatch, expected byte %h blk %0d pos %0d",
                                 $time, tag.byte_out, tag.block_index, tag.position,
                                 " data %b dlen %0d last %b",
                                 tag.is_data, tag.data_length, tag.last);
                        $display("%0t:               actual byte %h blk %0d pos %0d",
                                 $time, seen.byte_out, seen.block_index, seen.position,
                                 " data %b dlen %0d last %b",
                                 seen.is_data, seen.data_length, seen.last);
                        errors++;
                    end
                end
            end
        end
        outstanding <= expected_tags.size();
        fail_count  <= errors;
    end

endmodule

// File: dv/grid_matrix_block_deinterleaver_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_matrix_block_deinterleaver_core_test
// Drives raw codeword streams into the block deinterleaver under changing
// version and level settings: whole symbols of the small layouts, partial
// symbols of all layouts, bytes past the final codeword and restarts.
// Both channels stall at random; the checker judges every tag.
// ----------------------------------------------------------------------------
module grid_matrix_block_deinterleaver_core_test;

    localparam int TARGET_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 4;

    // codewords in one whole symbol, per version
    localparam int SYMBOL_SIZE [13] = '{
        18, 50, 98, 162, 242, 338, 450, 578, 722, 882, 1058, 1250, 1458
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    gmbd_pkg::cfg_addr_t cfg_addr    = gmbd_pkg::CFG_VERSION;
    logic [3:0]          cfg_wr_data = 4'd0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'd0;   // codeword
    logic                s_tuser     = 1'b0;   // start_req
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [31:0]         m_tdata;              // byte_out, block_index, position, data_length
    logic                m_tuser;              // is_data
    logic                m_tlast;

    int                  fail_count;
    int                  outstanding;
    int                  cycles      = 0;
    int                  fed_items   = 0;
    bit                  send_burst  = 1'b0;
    bit                  sink_burst  = 1'b0;
    logic [3:0]          cur_version = 4'd1;

    always #10 aclk = ~aclk;

    grid_matrix_block_deinterleaver_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    gmbd_tag_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_codeword(input logic [7:0] cw, input logic start);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cw;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_run(input int len, input bit first_start, input bit noisy);
        for (int i = 0; i < len; i++) begin
            send_codeword(8'($urandom_range(0, 255)),
                          (i == 0 && first_start) || (noisy && $urandom_range(0, 63) == 0));
        end
    endtask

    // no transaction in flight and nothing left to come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_config(input logic [3:0] ver, input logic [2:0] lvl,
                                input bit [1:0] sel);
        if (sel[0]) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= gmbd_pkg::CFG_VERSION;
            cfg_wr_data <= ver;
            cur_version  = ver;
            @(posedge aclk);
        end
        if (sel[1]) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= gmbd_pkg::CFG_EC_LEVEL;
            cfg_wr_data <= {1'b0, lvl};
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // result side
    initial begin
        int hold;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                sink_burst = !sink_burst;
            end
            hold = sink_burst ? 0 : $urandom_range(0, 16);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int eff;
        int len;
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no start yet: reset layout, a whole symbol, then a byte past its end
        for (int i = 0; i < 18; i++) begin
            send_codeword((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                          1'b0);
        end
        send_codeword(8'hFF, 1'b0);
        settle();
        write_config(4'd15, 3'd7, 2'b11);
        send_run(3, 1'b1, 1'b0);
        // shrink the layout under the running counters
        settle();
        write_config(4'd1, 3'd0, 2'b01);
        send_codeword(8'h5A, 1'b0);
        settle();
        write_config(4'd0, 3'd0, 2'b11);
        send_run(3, 1'b1, 1'b0);

        while (fed_items < TARGET_ITEMS) begin
            settle();
            pick = $urandom_range(0, 99);
            write_config(4'((pick < 70) ? $urandom_range(0, 4) : $urandom_range(0, 15)),
                         3'($urandom_range(0, 7)), 2'($urandom_range(1, 3)));
            eff        = (cur_version == 4'd0) ? 1 : (cur_version > 4'd13) ? 13 :
                         int'(cur_version);
            send_burst = ($urandom_range(0, 3) == 0);
            pick       = $urandom_range(0, 9);
            if (pick < 7 && SYMBOL_SIZE[eff - 1] <= 250) begin
                len = SYMBOL_SIZE[eff - 1];
                send_run(len, 1'b1, 1'b0);
                send_run($urandom_range(0, 2), 1'b0, 1'b0);
            end else begin
                len = $urandom_range(1, 100);
                send_run(len, pick != 9, 1'b1);
            end
            fed_items += len;
        end

        settle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
